[rtl/lpmd_pkg.sv]
// lpmd_pkg: types and constants for the length-prefixed multipart deframer
// no dependencies; imported by length_prefixed_multipart_deframer

package lpmd_pkg;

  typedef enum logic [2:0] {
    PH_SEQ_LEN   = 3'd0,
    PH_SEQ_BYTES = 3'd1,
    PH_FLAGS     = 3'd2,
    PH_COUNT     = 3'd3,
    PH_PART_LEN  = 3'd4,
    PH_PART_DATA = 3'd5,
    PH_TRAILING  = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    KIND_HEADER = 3'd0,
    KIND_BYTE   = 3'd1,
    KIND_EMPTY  = 3'd2,
    KIND_DONE   = 3'd3,
    KIND_SHORT  = 3'd4,
    KIND_TRUNC  = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] seq_number;
    logic        seq_exact;
    logic [7:0]  flag_bits;
    logic [15:0] part_total;
    logic [15:0] part_index;
    logic [7:0]  data_byte;
    logic        part_done;
    logic        fragment_continues;
    logic        last_result;
  } result_t;

  localparam logic [15:0] SEQ_FULL_LEN   = 16'd8;
  localparam logic [7:0]  FLAG_CONTINUES = 8'd2;
  localparam int          RES_DEPTH      = 4;
  localparam int          RES_PTR_W      = $clog2(RES_DEPTH);
  localparam int          RES_CNT_W      = $clog2(RES_DEPTH + 1);
  localparam int          TDATA_W        = 120;

endpackage

[rtl/length_prefixed_multipart_deframer.sv]
// length_prefixed_multipart_deframer: byte-wise parser of length-prefixed multipart packets
// depends on lpmd_pkg
//
// channel  dir  tdata (low bit up)                              tuser  tlast
// s_axis   in   in_byte                                         -      packet_end
// m_axis   out  seq_number, seq_exact, flag_bits, part_total,   kind   last_result
//               part_index, data_byte, part_done,
//               fragment_continues, zero pad to 120 bits
//
// one byte per cycle: a byte is held in the input register, then the parse
// logic updates the field state and pushes zero, one or two results into a 4-entry
// result queue; a byte waits while fewer than two queue entries are free.
// reset clears the parse state and empties the queue; no clearing pass.
// a stalled m_axis side fills the queue and then holds s_axis_tready low.

module length_prefixed_multipart_deframer
  import lpmd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // in_byte
  input  logic               s_axis_tlast,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // seq_number, seq_exact, flag_bits, part_total, part_index, data_byte,
  // part_done, fragment_continues, zero pad
  output logic [TDATA_W-1:0] m_axis_tdata,
  output logic [2:0]         m_axis_tuser,   // kind
  output logic               m_axis_tlast
);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_end;

  // parse state
  phase_t      phase, phase_next;
  logic [15:0] field_counter, field_counter_next;
  logic [15:0] seq_len_reg, seq_len_reg_next;
  logic [63:0] seq_accum, seq_accum_next;
  logic [7:0]  flags_reg, flags_reg_next;
  logic [15:0] count_reg, count_reg_next;
  logic [15:0] part_number, part_number_next;
  logic [15:0] part_remaining, part_remaining_next;
  logic [7:0]  length_high, length_high_next;

  // result queue
  result_t               res_q [RES_DEPTH];
  logic [RES_PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [RES_CNT_W-1:0]  res_count;

  logic        process;
  logic        pop;
  logic [15:0] field16;
  logic [15:0] seq_cnt_inc;
  logic [15:0] part_inc;
  logic [15:0] rem_dec;
  logic        frag;
  result_t     res_a, res_b;
  logic [1:0]  res_n;

  assign process     = in_valid && (res_count <= RES_CNT_W'(RES_DEPTH - 2));
  assign pop         = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = !in_valid || process;

  assign field16     = {length_high, in_byte};
  assign seq_cnt_inc = field_counter + 16'd1;
  assign part_inc    = part_number + 16'd1;
  assign rem_dec     = part_remaining - 16'd1;
  assign frag        = ({1'b0, part_number} + 17'd1 == {1'b0, count_reg}) &&
                       (flags_reg == FLAG_CONTINUES);

  // next state
  always_comb begin
    phase_next          = phase;
    field_counter_next  = field_counter;
    seq_len_reg_next    = seq_len_reg;
    seq_accum_next      = seq_accum;
    flags_reg_next      = flags_reg;
    count_reg_next      = count_reg;
    part_number_next    = part_number;
    part_remaining_next = part_remaining;
    length_high_next    = length_high;
    case (phase)
      PH_SEQ_LEN: begin
        if (field_counter == 16'd0) begin
          length_high_next   = in_byte;
          field_counter_next = 16'd1;
        end else begin
          seq_len_reg_next   = field16;
          field_counter_next = 16'd0;
          phase_next         = (field16 != 16'd0) ? PH_SEQ_BYTES : PH_FLAGS;
        end
      end
      PH_SEQ_BYTES: begin
        seq_accum_next     = {seq_accum[55:0], in_byte};
        field_counter_next = seq_cnt_inc;
        if (seq_cnt_inc == seq_len_reg) begin
          field_counter_next = 16'd0;
          phase_next         = PH_FLAGS;
        end
      end
      PH_FLAGS: begin
        flags_reg_next     = in_byte;
        field_counter_next = 16'd0;
        phase_next         = PH_COUNT;
      end
      PH_COUNT: begin
        if (field_counter == 16'd0) begin
          length_high_next   = in_byte;
          field_counter_next = 16'd1;
        end else begin
          count_reg_next     = field16;
          field_counter_next = 16'd0;
          part_number_next   = 16'd0;
          phase_next         = (field16 == 16'd0) ? PH_TRAILING : PH_PART_LEN;
        end
      end
      PH_PART_LEN: begin
        if (field_counter == 16'd0) begin
          length_high_next   = in_byte;
          field_counter_next = 16'd1;
        end else begin
          field_counter_next = 16'd0;
          if (field16 == 16'd0) begin
            part_number_next = part_inc;
            phase_next       = (part_inc == count_reg) ? PH_TRAILING : PH_PART_LEN;
          end else begin
            part_remaining_next = field16;
            phase_next          = PH_PART_DATA;
          end
        end
      end
      PH_PART_DATA: begin
        part_remaining_next = rem_dec;
        if (rem_dec == 16'd0) begin
          part_number_next   = part_inc;
          field_counter_next = 16'd0;
          phase_next         = (part_inc == count_reg) ? PH_TRAILING : PH_PART_LEN;
        end
      end
      default: begin
      end
    endcase
  end

  // results for the byte in the input register
  always_comb begin
    result_t hdr;
    result_t m0, m1, e0;
    logic    m0_v, m1_v, e0_v;

    hdr                    = '0;
    hdr.seq_number         = seq_accum_next;
    hdr.seq_exact          = (seq_len_reg_next == SEQ_FULL_LEN);
    hdr.flag_bits          = flags_reg_next;
    hdr.part_total         = count_reg_next;

    m0   = hdr;
    m1   = hdr;
    m1.kind = KIND_DONE;
    m0_v = 1'b0;
    m1_v = 1'b0;

    case (phase)
      PH_COUNT: begin
        if (field_counter != 16'd0) begin
          m0.kind = KIND_HEADER;
          m0_v    = 1'b1;
          m1_v    = (field16 == 16'd0);
        end
      end
      PH_PART_LEN: begin
        if (field_counter != 16'd0 && field16 == 16'd0) begin
          m0.kind               = KIND_EMPTY;
          m0.part_index         = part_number;
          m0.part_done          = 1'b1;
          m0.fragment_continues = frag;
          m0_v                  = 1'b1;
          m1_v                  = (part_inc == count_reg);
        end
      end
      PH_PART_DATA: begin
        m0.kind               = KIND_BYTE;
        m0.part_index         = part_number;
        m0.data_byte          = in_byte;
        m0.part_done          = (rem_dec == 16'd0);
        m0.fragment_continues = frag;
        m0_v                  = 1'b1;
        m1_v                  = (rem_dec == 16'd0) && (part_inc == count_reg);
      end
      default: begin
      end
    endcase

    e0   = '0;
    e0_v = 1'b0;
    if (in_end) begin
      if (phase_next == PH_SEQ_LEN || phase_next == PH_SEQ_BYTES ||
          phase_next == PH_FLAGS || phase_next == PH_COUNT) begin
        e0.kind = KIND_SHORT;
        e0_v    = 1'b1;
      end else if (phase_next == PH_PART_LEN || phase_next == PH_PART_DATA) begin
        e0            = hdr;
        e0.kind       = KIND_TRUNC;
        e0.part_index = part_number_next;
        e0_v          = 1'b1;
      end
    end

    res_a = m0_v ? m0 : e0;
    res_b = m1_v ? m1 : e0;
    res_n = 2'(m0_v) + 2'(m1_v) + 2'(e0_v);
    res_a.last_result = (res_n == 2'd1);
    res_b.last_result = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_end  <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (process && in_end)) begin
      phase          <= PH_SEQ_LEN;
      field_counter  <= '0;
      seq_len_reg    <= '0;
      seq_accum      <= '0;
      flags_reg      <= '0;
      count_reg      <= '0;
      part_number    <= '0;
      part_remaining <= '0;
      length_high    <= '0;
    end else if (process) begin
      phase          <= phase_next;
      field_counter  <= field_counter_next;
      seq_len_reg    <= seq_len_reg_next;
      seq_accum      <= seq_accum_next;
      flags_reg      <= flags_reg_next;
      count_reg      <= count_reg_next;
      part_number    <= part_number_next;
      part_remaining <= part_remaining_next;
      length_high    <= length_high_next;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      res_count <= '0;
    end else begin
      if (process) begin
        wr_ptr <= wr_ptr + RES_PTR_W'(res_n);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + RES_PTR_W'(1);
      end
      res_count <= res_count + (process ? RES_CNT_W'(res_n) : RES_CNT_W'(0))
                   - RES_CNT_W'(pop);
    end
    if (process && res_n != 2'd0) begin
      res_q[wr_ptr] <= res_a;
    end
    if (process && res_n == 2'd2) begin
      res_q[wr_ptr + RES_PTR_W'(1)] <= res_b;
    end
  end

  always_comb begin
    result_t head;
    head          = res_q[rd_ptr];
    m_axis_tvalid = (res_count != '0);
    m_axis_tuser  = head.kind;
    m_axis_tlast  = head.last_result;
    m_axis_tdata  = {5'd0, head.fragment_continues, head.part_done, head.data_byte,
                     head.part_index, head.part_total, head.flag_bits,
                     head.seq_exact, head.seq_number};
  end

endmodule
